// ===== rtl/core/pat_pkg.sv =====
// Shared types and constants for the Paxos acceptor table unit.
// Holds the operation codes, the control entry layout and field widths.
// Used by pat_rule and paxos_acceptor_table_unit; depends on nothing.
package pat_pkg;

  localparam int unsigned BALLOT_W       = 32;
  localparam int unsigned INST_REQ_W     = 10;
  localparam int unsigned FIELD_VALUE_W  = 64;
  localparam int unsigned DEF_INSTANCES  = 1024;
  localparam int unsigned DEF_VALUE_BITS = 64;

  typedef enum logic [1:0] {
    OP_PREPARE = 2'd0,
    OP_ACCEPT  = 2'd1,
    OP_COMMIT  = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef struct packed {
    logic signed [BALLOT_W-1:0] promise_major;
    logic signed [BALLOT_W-1:0] promise_minor;
    logic                       accepted;
    logic                       committed;
  } pat_ctrl_t;

  typedef struct packed {
    logic granted;
    logic data_we;
    logic accepted;
    logic committed;
  } pat_verdict_t;

  localparam pat_ctrl_t CTRL_RESET = '{
    promise_major: '1,
    promise_minor: '1,
    accepted:      1'b0,
    committed:     1'b0
  };

endpackage

// ===== rtl/core/pat_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/pat_rule.sv =====
// Acceptor decision logic: compares the request ballot with the stored promise,
// forms the updated control entry and the reply. Depends on pat_pkg.
module pat_rule #(
  parameter int unsigned VALUE_BITS = pat_pkg::DEF_VALUE_BITS
) (
  input  pat_pkg::op_e                          op_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]   ballot_major_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]   ballot_minor_i,
  input  logic [VALUE_BITS-1:0]                 value_i,
  input  pat_pkg::pat_ctrl_t                    ctrl_rd_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]   acc_major_rd_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]   acc_minor_rd_i,
  input  logic [VALUE_BITS-1:0]                 acc_value_rd_i,
  output pat_pkg::pat_ctrl_t                    ctrl_new_o,
  output pat_pkg::pat_verdict_t                 verdict_o,
  output logic signed [pat_pkg::BALLOT_W-1:0]   reply_major_o,
  output logic signed [pat_pkg::BALLOT_W-1:0]   reply_minor_o,
  output logic [VALUE_BITS-1:0]                 reply_value_o
);

  import pat_pkg::*;

  logic ballot_gt;
  logic ballot_eq;
  logic fresh;

  assign ballot_gt = (ballot_major_i > ctrl_rd_i.promise_major) ||
                     ((ballot_major_i == ctrl_rd_i.promise_major) &&
                      (ballot_minor_i > ctrl_rd_i.promise_minor));
  assign ballot_eq = (ballot_major_i == ctrl_rd_i.promise_major) &&
                     (ballot_minor_i == ctrl_rd_i.promise_minor);

  always_comb begin
    ctrl_new_o = ctrl_rd_i;
    verdict_o  = '0;
    fresh      = 1'b0;
    unique case (op_i)
      OP_PREPARE: begin
        if (ballot_gt) begin
          ctrl_new_o.promise_major = ballot_major_i;
          ctrl_new_o.promise_minor = ballot_minor_i;
          verdict_o.granted        = 1'b1;
          fresh                    = 1'b1;
        end
      end
      OP_ACCEPT: begin
        if (ballot_gt || ballot_eq) begin
          ctrl_new_o.promise_major = ballot_major_i;
          ctrl_new_o.promise_minor = ballot_minor_i;
          ctrl_new_o.accepted      = 1'b1;
          verdict_o.granted        = 1'b1;
          verdict_o.data_we        = 1'b1;
        end
      end
      OP_COMMIT: begin
        if (!ctrl_rd_i.committed) begin
          ctrl_new_o.committed = 1'b1;
          verdict_o.granted    = 1'b1;
        end
      end
      OP_QUERY: begin
        verdict_o.granted = 1'b1;
      end
      default: begin
        verdict_o.granted = 1'b0;
      end
    endcase
    verdict_o.accepted  = ctrl_new_o.accepted;
    verdict_o.committed = ctrl_new_o.committed;
  end

  always_comb begin
    reply_major_o = '0;
    reply_minor_o = '0;
    reply_value_o = '0;
    if (verdict_o.data_we) begin
      reply_major_o = ballot_major_i;
      reply_minor_o = ballot_minor_i;
      reply_value_o = value_i;
    end else if (ctrl_rd_i.accepted) begin
      reply_major_o = acc_major_rd_i;
      reply_minor_o = acc_minor_rd_i;
      reply_value_o = acc_value_rd_i;
    end else if (fresh) begin
      reply_major_o = ballot_major_i;
      reply_minor_o = ballot_minor_i;
    end
  end

endmodule

// ===== rtl/core/paxos_acceptor_table_unit.sv =====
// Top level of the multi-instance Paxos acceptor table.
// Instantiates pat_ram twice and pat_rule; depends on pat_pkg.
//
//   Channel   Handshake                Payload
//   request   start / busy             operation_i, instance_req_i, ballot_major_i,
//                                      ballot_minor_i, proposed_value_i
//   result    result_valid_o (strobe)  granted_o, accepted_o, reply_major_o,
//                                      reply_minor_o, reply_value_o, is_committed_o
//
// Each transaction runs as the table read, then the decision and write-back.
// The result strobe comes in the cycle after that, when the next start may be taken.
// After reset the control memory is cleared one entry per cycle, with busy held high
// until every entry has been written. The receiver cannot stall the result.
module paxos_acceptor_table_unit #(
  parameter int unsigned INSTANCES  = pat_pkg::DEF_INSTANCES,
  parameter int unsigned VALUE_BITS = pat_pkg::DEF_VALUE_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               operation_i,
  input  logic [pat_pkg::INST_REQ_W-1:0]           instance_req_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]      ballot_major_i,
  input  logic signed [pat_pkg::BALLOT_W-1:0]      ballot_minor_i,
  input  logic [pat_pkg::FIELD_VALUE_W-1:0]        proposed_value_i,
  output logic                                     result_valid_o,
  output logic                                     granted_o,
  output logic                                     accepted_o,
  output logic signed [pat_pkg::BALLOT_W-1:0]      reply_major_o,
  output logic signed [pat_pkg::BALLOT_W-1:0]      reply_minor_o,
  output logic [pat_pkg::FIELD_VALUE_W-1:0]        reply_value_o,
  output logic                                     is_committed_o
);

  import pat_pkg::*;

  localparam int unsigned AW     = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int unsigned XW     = (AW > INST_REQ_W) ? AW : INST_REQ_W;
  localparam int unsigned DATA_W = 2 * BALLOT_W + VALUE_BITS;
  localparam int unsigned CTRL_W = $bits(pat_ctrl_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] addr_q;
  logic          in_range_q;
  op_e           op_q;
  logic signed [BALLOT_W-1:0] bmaj_q;
  logic signed [BALLOT_W-1:0] bmin_q;
  logic [VALUE_BITS-1:0]      val_q;

  logic          take;
  logic          in_range;
  logic [XW-1:0] inst_ext;
  logic [AW-1:0] raddr;

  logic          ctrl_we;
  logic [AW-1:0] ctrl_waddr;
  pat_ctrl_t     ctrl_wdata;
  logic [CTRL_W-1:0] ctrl_rdata;
  pat_ctrl_t     ctrl_rd;
  logic          data_we;
  logic [DATA_W-1:0] data_wdata;
  logic [DATA_W-1:0] data_rdata;

  pat_ctrl_t     ctrl_new;
  pat_verdict_t  verdict;
  logic signed [BALLOT_W-1:0] rule_major;
  logic signed [BALLOT_W-1:0] rule_minor;
  logic [VALUE_BITS-1:0]      rule_value;

  assign busy     = (state_q != ST_IDLE);
  assign take     = start && !busy;
  assign inst_ext = XW'(instance_req_i);
  assign in_range = (32'(instance_req_i) < 32'(INSTANCES));
  assign raddr    = inst_ext[AW-1:0];

  assign ctrl_rd    = pat_ctrl_t'(ctrl_rdata);
  assign ctrl_we    = (state_q == ST_CLEAR) || ((state_q == ST_EXEC) && in_range_q);
  assign ctrl_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
  assign ctrl_wdata = (state_q == ST_CLEAR) ? CTRL_RESET : ctrl_new;
  assign data_we    = (state_q == ST_EXEC) && in_range_q && verdict.data_we;
  assign data_wdata = {bmaj_q, bmin_q, val_q};

  pat_ram #(
    .WIDTH (CTRL_W),
    .DEPTH (INSTANCES)
  ) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (ctrl_waddr),
    .wdata_i (CTRL_W'(ctrl_wdata)),
    .raddr_i (raddr),
    .rdata_o (ctrl_rdata)
  );

  pat_ram #(
    .WIDTH (DATA_W),
    .DEPTH (INSTANCES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (addr_q),
    .wdata_i (data_wdata),
    .raddr_i (raddr),
    .rdata_o (data_rdata)
  );

  pat_rule #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rule (
    .op_i           (op_q),
    .ballot_major_i (bmaj_q),
    .ballot_minor_i (bmin_q),
    .value_i        (val_q),
    .ctrl_rd_i      (ctrl_rd),
    .acc_major_rd_i (data_rdata[DATA_W-1 -: BALLOT_W]),
    .acc_minor_rd_i (data_rdata[VALUE_BITS +: BALLOT_W]),
    .acc_value_rd_i (data_rdata[VALUE_BITS-1:0]),
    .ctrl_new_o     (ctrl_new),
    .verdict_o      (verdict),
    .reply_major_o  (rule_major),
    .reply_minor_o  (rule_minor),
    .reply_value_o  (rule_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == AW'(INSTANCES - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (take) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q        <= ST_IDLE;
          result_valid_o <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q       <= op_e'(operation_i);
      addr_q     <= raddr;
      in_range_q <= in_range;
      bmaj_q     <= ballot_major_i;
      bmin_q     <= ballot_minor_i;
      val_q      <= proposed_value_i[VALUE_BITS-1:0];
    end
    if (state_q == ST_EXEC) begin
      if (in_range_q) begin
        granted_o      <= verdict.granted;
        accepted_o     <= verdict.accepted;
        reply_major_o  <= rule_major;
        reply_minor_o  <= rule_minor;
        reply_value_o  <= FIELD_VALUE_W'(rule_value);
        is_committed_o <= verdict.committed;
      end else begin
        granted_o      <= 1'b0;
        accepted_o     <= 1'b0;
        reply_major_o  <= '0;
        reply_minor_o  <= '0;
        reply_value_o  <= '0;
        is_committed_o <= 1'b0;
      end
    end
  end

endmodule
